// File: hdl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the clock, off during reset.
`define BVOP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold, off during reset.
`define BVOP_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hdl/bvop_pkg.sv
// Types, codes and constants of the BOOTP vendor option parser.
// No dependencies; used by the other .sv files through scoped names.
`default_nettype none

package bvop_pkg;

   // default vendor area length in bytes
   localparam int AREA_BYTES_DEF = 64;

   // magic cookie 99.130.83.99, first byte first
   localparam logic [7:0] COOKIE [4] = '{8'd99, 8'd130, 8'd83, 8'd99};
   localparam int COOKIE_LEN = 4;

   // option codes
   localparam logic [7:0] CODE_PAD     = 8'd0;
   localparam logic [7:0] CODE_SUBNET  = 8'd1;
   localparam logic [7:0] CODE_GATEWAY = 8'd3;
   localparam logic [7:0] CODE_SERVER  = 8'd6;
   localparam logic [7:0] CODE_END     = 8'd255;

   // capture slot bits
   localparam int SLOT_SUBNET  = 0;
   localparam int SLOT_GATEWAY = 1;
   localparam int SLOT_SERVER  = 2;
   localparam int SLOTS        = 3;

   // captured value width and count of value bytes kept
   localparam int VALUE_W     = 32;
   localparam int VALUE_BYTES = 4;

   typedef enum logic [4:0] {
      PH_COOKIE = 5'b00001,
      PH_CODE   = 5'b00010,
      PH_LEN    = 5'b00100,
      PH_VALUE  = 5'b01000,
      PH_IDLE   = 5'b10000
   } bvop_phase_type;

   typedef struct packed {
      logic               cookie_ok;
      logic [VALUE_W-1:0] subnet_mask;
      logic               subnet_found;
      logic [VALUE_W-1:0] gateway_address;
      logic               gateway_found;
      logic [VALUE_W-1:0] name_server_address;
      logic               name_server_found;
      logic               end_seen;
   } bvop_result_type;

   // one-hot capture slot of an option code, zero if not captured
   function automatic logic [SLOTS-1:0] slot_mask(input logic [7:0] code);
      logic [SLOTS-1:0] m;
      m = '0;
      case (code)
         CODE_SUBNET:  m[SLOT_SUBNET]  = 1'b1;
         CODE_GATEWAY: m[SLOT_GATEWAY] = 1'b1;
         CODE_SERVER:  m[SLOT_SERVER]  = 1'b1;
         default:      m = '0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// File: hdl/bvop_channels.sv
// Valid/ready channel interfaces for vendor area bytes and parse results.
// Depends on bvop_pkg.
`default_nettype none

interface bvop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] area_byte;
   logic       area_last;

   modport source (output valid, output area_byte, output area_last, input ready);
   modport sink   (input valid, input area_byte, input area_last, output ready);
endinterface

interface bvop_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            cookie_ok;
   logic [bvop_pkg::VALUE_W-1:0]    subnet_mask;
   logic                            subnet_found;
   logic [bvop_pkg::VALUE_W-1:0]    gateway_address;
   logic                            gateway_found;
   logic [bvop_pkg::VALUE_W-1:0]    name_server_address;
   logic                            name_server_found;
   logic                            end_seen;

   modport source (
      output valid, output cookie_ok, output subnet_mask, output subnet_found,
      output gateway_address, output gateway_found, output name_server_address,
      output name_server_found, output end_seen, input ready
   );
   modport sink (
      input valid, input cookie_ok, input subnet_mask, input subnet_found,
      input gateway_address, input gateway_found, input name_server_address,
      input name_server_found, input end_seen, output ready
   );
endinterface

`default_nettype wire

// File: hdl/bootp_vendor_option_parser.sv
// BOOTP vendor area parser. Takes the vendor area one byte per request, checks
// the magic cookie 99.130.83.99, walks the options and on the byte marked last
// returns one response with subnet mask, gateway and first name server (first
// value byte most significant, short values zero-filled), their found flags,
// the cookie result and whether the end option was reached; it then starts
// over for the next area. One byte is taken every cycle unless stalled: each
// byte is held in an input register and updates the parse state as it leaves
// it, where a closing byte also lands in the response register. The only
// stall is a full response register that is not being drained. Bytes at or
// beyond AREA_BYTES are ignored by the option walk.
// Depends on bvop_pkg, bvop_channels, bvop_parser, bvop_out_reg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bootp_vendor_option_parser #(
   parameter int AREA_BYTES = bvop_pkg::AREA_BYTES_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   bvop_req_if.sink   req_chan,
   bvop_rsp_if.source rsp_chan
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      in_last_ff;
   logic                      req_take;
   logic                      consume;
   logic                      out_load;
   logic                      out_can_load;
   bvop_pkg::bvop_result_type result;

   // a held byte moves on unless it closes an area and the response is blocked
   assign consume        = in_valid_ff && (!in_last_ff || out_can_load);
   assign out_load       = consume && in_last_ff;
   assign req_chan.ready = !in_valid_ff || consume;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_take || (in_valid_ff && !consume);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.area_byte;
         in_last_ff <= req_chan.area_last;
      end
   end

   bvop_parser #(
      .AREA_BYTES (AREA_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (consume),
      .area_byte (in_byte_ff),
      .area_last (in_last_ff),
      .result    (result)
   );

   bvop_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (out_load),
      .data     (result),
      .can_load (out_can_load),
      .rsp      (rsp_chan)
   );

   // checks
   `BVOP_ASSERT(a_rsp_from_last, clock, reset, (rsp_chan.valid && !$past(rsp_chan.valid)) |-> $past(out_load), "response appeared without a closing byte")
   `BVOP_NEVER(a_no_overwrite, clock, reset, out_load && rsp_chan.valid && !rsp_chan.ready, "pending response overwritten")
   `BVOP_ASSERT(a_in_reg_free, clock, reset, (req_take && in_valid_ff) |-> consume, "held byte overwritten before use")

endmodule

`default_nettype wire

// File: hdl/bvop_parser.sv
// Per-byte option walker: cookie check, code/length/value phases, captures.
// Depends on bvop_pkg. Gives the result that the current byte would close.
`default_nettype none

module bvop_parser #(
   parameter int AREA_BYTES = bvop_pkg::AREA_BYTES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       take,
   input  wire logic [7:0]                 area_byte,
   input  wire logic                       area_last,
   output      bvop_pkg::bvop_result_type  result
);

   localparam int PW = $clog2(AREA_BYTES + 1);
   localparam int CW = $clog2(bvop_pkg::VALUE_BYTES + 1);
   localparam int VW = bvop_pkg::VALUE_W;
   localparam int SL = bvop_pkg::SLOTS;

   logic [PW-1:0]            pos_ff, pos_in;
   bvop_pkg::bvop_phase_type phase_ff, phase_in;
   logic [7:0]               code_ff, code_in;
   logic [7:0]               remain_ff, remain_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [VW-1:0]            shift_ff, shift_in;
   logic [VW-1:0]            subnet_ff, subnet_in;
   logic [VW-1:0]            gateway_ff, gateway_in;
   logic [VW-1:0]            server_ff, server_in;
   logic [SL-1:0]            found_ff, found_in;
   logic                     match_ff, match_in;
   logic                     stopped_ff, stopped_in;

   logic                     hit;
   logic [SL-1:0]            mask;

   // next parse state for the byte at the input
   always_comb begin
      pos_in     = (pos_ff == PW'(AREA_BYTES)) ? pos_ff : pos_ff + PW'(1);
      phase_in   = phase_ff;
      code_in    = code_ff;
      remain_in  = remain_ff;
      count_in   = count_ff;
      shift_in   = shift_ff;
      subnet_in  = subnet_ff;
      gateway_in = gateway_ff;
      server_in  = server_ff;
      found_in   = found_ff;
      match_in   = match_ff;
      stopped_in = stopped_ff;
      mask       = bvop_pkg::slot_mask(code_ff);
      hit        = (pos_ff < PW'(bvop_pkg::COOKIE_LEN)) &&
                   (area_byte == bvop_pkg::COOKIE[pos_ff[1:0]]);

      if (phase_ff == bvop_pkg::PH_COOKIE) begin
         match_in = (pos_ff == '0) ? hit : (match_ff & hit);
         if (pos_ff >= PW'(bvop_pkg::COOKIE_LEN - 1)) begin
            phase_in = match_in ? bvop_pkg::PH_CODE : bvop_pkg::PH_IDLE;
         end
      end else if (pos_ff < PW'(AREA_BYTES)) begin
         unique case (phase_ff)
            bvop_pkg::PH_CODE: begin
               if (area_byte == bvop_pkg::CODE_END) begin
                  stopped_in = 1'b1;
                  phase_in   = bvop_pkg::PH_IDLE;
               end else if (area_byte != bvop_pkg::CODE_PAD) begin
                  code_in  = area_byte;
                  phase_in = bvop_pkg::PH_LEN;
               end
            end
            bvop_pkg::PH_LEN: begin
               remain_in = area_byte;
               count_in  = '0;
               shift_in  = '0;
               if (mask[bvop_pkg::SLOT_SUBNET])  subnet_in  = '0;
               if (mask[bvop_pkg::SLOT_GATEWAY]) gateway_in = '0;
               if (mask[bvop_pkg::SLOT_SERVER])  server_in  = '0;
               found_in  = found_ff | mask;
               phase_in  = (area_byte == 8'd0) ? bvop_pkg::PH_CODE : bvop_pkg::PH_VALUE;
            end
            bvop_pkg::PH_VALUE: begin
               // keep the first four value bytes, first one on top
               if ((mask != '0) && (count_ff < CW'(bvop_pkg::VALUE_BYTES))) begin
                  case (count_ff[1:0])
                     2'd0:    shift_in[31:24] = area_byte;
                     2'd1:    shift_in[23:16] = area_byte;
                     2'd2:    shift_in[15:8]  = area_byte;
                     default: shift_in[7:0]   = area_byte;
                  endcase
                  count_in = count_ff + CW'(1);
                  if (mask[bvop_pkg::SLOT_SUBNET])  subnet_in  = shift_in;
                  if (mask[bvop_pkg::SLOT_GATEWAY]) gateway_in = shift_in;
                  if (mask[bvop_pkg::SLOT_SERVER])  server_in  = shift_in;
               end
               remain_in = remain_ff - 8'd1;
               if (remain_in == 8'd0) phase_in = bvop_pkg::PH_CODE;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // result as it stands after this byte
   always_comb begin
      result.cookie_ok           = (phase_in != bvop_pkg::PH_COOKIE) && match_in;
      result.subnet_mask         = subnet_in;
      result.subnet_found        = found_in[bvop_pkg::SLOT_SUBNET];
      result.gateway_address     = gateway_in;
      result.gateway_found       = found_in[bvop_pkg::SLOT_GATEWAY];
      result.name_server_address = server_in;
      result.name_server_found   = found_in[bvop_pkg::SLOT_SERVER];
      result.end_seen            = stopped_in;
   end

   // parse state; a closing byte returns it to the start of an area
   always_ff @(posedge clock) begin
      if (reset || (take && area_last)) begin
         pos_ff     <= '0;
         phase_ff   <= bvop_pkg::PH_COOKIE;
         code_ff    <= '0;
         remain_ff  <= '0;
         count_ff   <= '0;
         shift_ff   <= '0;
         subnet_ff  <= '0;
         gateway_ff <= '0;
         server_ff  <= '0;
         found_ff   <= '0;
         match_ff   <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (take) begin
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         code_ff    <= code_in;
         remain_ff  <= remain_in;
         count_ff   <= count_in;
         shift_ff   <= shift_in;
         subnet_ff  <= subnet_in;
         gateway_ff <= gateway_in;
         server_ff  <= server_in;
         found_ff   <= found_in;
         match_ff   <= match_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/bvop_out_reg.sv
// Result register driving the response channel.
// Depends on bvop_pkg and bvop_channels.
`default_nettype none

module bvop_out_reg (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire bvop_pkg::bvop_result_type  data,
   output      logic                       can_load,
   bvop_rsp_if.source                      rsp
);

   logic                      valid_ff, valid_in;
   bvop_pkg::bvop_result_type data_ff;

   // free when empty or when the held result leaves this cycle
   assign can_load = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp.valid               = valid_ff;
   assign rsp.cookie_ok           = data_ff.cookie_ok;
   assign rsp.subnet_mask         = data_ff.subnet_mask;
   assign rsp.subnet_found        = data_ff.subnet_found;
   assign rsp.gateway_address     = data_ff.gateway_address;
   assign rsp.gateway_found       = data_ff.gateway_found;
   assign rsp.name_server_address = data_ff.name_server_address;
   assign rsp.name_server_found   = data_ff.name_server_found;
   assign rsp.end_seen            = data_ff.end_seen;

endmodule

`default_nettype wire
